// ===== hw/rtl/atpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_pkg: shared types and constants for the tilt-angle unit
// CORDIC datapath widths, the arctangent table in degrees (Q20), the gain
// constant and the sideband records that travel along the two chains.
// ----------------------------------------------------------------------------
package atpr_pkg;

  localparam int unsigned CORDIC_STEPS_DEF    = 16;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 8;

  localparam int unsigned IN_W    = 13;  // sample width
  localparam int unsigned VEC_W   = 34;  // vector component, counts * 2^16
  localparam int unsigned ANG_W   = 32;  // angle accumulator, degrees * 2^20
  localparam int unsigned NXK_W   = 32;  // -x * gain, Q16
  localparam int unsigned PROD_W  = 30;  // |z| * gain, Q16
  localparam int unsigned ACC_FRAC = 20;
  localparam int unsigned TABLE_LEN = 24;
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned ROLL_W  = 17;

  // CORDIC gain in Q16
  localparam logic signed [NXK_W-1:0] GAIN_Q16 = 32'sd107922;

  localparam logic signed [ANG_W-1:0] DEG90_ACC  = 32'sd94371840;
  localparam logic signed [ANG_W-1:0] DEG180_ACC = 32'sd188743680;

  // atan(2^-i) in degrees, Q20
  localparam logic signed [ANG_W-1:0] ATAN_Q20 [TABLE_LEN] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7
  };

  // How the pitch angle is formed at the end of the second chain
  typedef enum logic [1:0] {
    PITCH_CHAIN,
    PITCH_ZERO,
    PITCH_POS90,
    PITCH_NEG90
  } pitch_sel_e;

  // Sideband riding along the roll chain
  typedef struct packed {
    logic signed [NXK_W-1:0] nxk;
    logic                    y_zero;
    logic                    z_neg;
    logic                    z_zero;
    logic [IN_W-1:0]         z_abs;
  } roll_side_t;

  // Sideband riding along the pitch chain
  typedef struct packed {
    logic signed [ANG_W-1:0] roll_acc;
    pitch_sel_e              pitch_sel;
  } pitch_side_t;

endpackage

// ===== hw/rtl/accel_tilt_pitch_roll_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle while the skid stage is empty, set by the two unrolled rows of CORDIC cells.
// A result waiting at the output does not block intake; a one-entry skid stage
// absorbs the next result, and only a full skid stage stalls the pipeline.
// Reset clears every valid flag, output and skid stage included; payload is not reset.
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_unit: pitch and roll from a three-axis sample
// Roll = atan2(y, z) from the first CORDIC chain, which also yields the
// gain-scaled magnitude of (z, y). Pitch = atan2(-x, |(y, z)|) from the
// second chain. Angles in degrees with ANGLE_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_unit #(
  parameter int unsigned CORDIC_STEPS    = atpr_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = atpr_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [atpr_pkg::IN_W-1:0]      accel_x_i,
  input  logic signed [atpr_pkg::IN_W-1:0]      accel_y_i,
  input  logic signed [atpr_pkg::IN_W-1:0]      accel_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [atpr_pkg::PITCH_W-1:0]   pitch_deg_o,
  output logic signed [atpr_pkg::ROLL_W-1:0]    roll_deg_o
);

  localparam int unsigned VEC_W = atpr_pkg::VEC_W;
  localparam int unsigned ANG_W = atpr_pkg::ANG_W;
  localparam int unsigned IN_W  = atpr_pkg::IN_W;
  localparam int unsigned RSIDE_W = $bits(atpr_pkg::roll_side_t);
  localparam int unsigned PSIDE_W = $bits(atpr_pkg::pitch_side_t);

  // Q20 -> Q(ANGLE_FRAC_BITS) conversion constants
  localparam int unsigned QSH = atpr_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] HALF_LSB  = ANG_W'(1) <<< (QSH - 1);
  localparam logic signed [ANG_W-1:0] LIM_PITCH = atpr_pkg::DEG90_ACC >>> QSH;
  localparam logic signed [ANG_W-1:0] LIM_ROLL  = atpr_pkg::DEG180_ACC >>> QSH;

  // Round to nearest (ties up), then clamp symmetric
  function automatic logic signed [ANG_W-1:0] quantize(
    input logic signed [ANG_W-1:0] acc,
    input logic signed [ANG_W-1:0] lim
  );
    logic signed [ANG_W-1:0] q;
    q = (acc + HALF_LSB) >>> QSH;
    if (q > lim) begin
      q = lim;
    end else if (q < -lim) begin
      q = -lim;
    end
    return q;
  endfunction

  // Global pipeline advance: hold everything only while the skid stage is full
  logic en;
  logic skid_valid_q, skid_valid_d;
  logic out_valid_q, out_valid_d;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Entry stage: fold z into the right half plane, scale to Q16, form -x * K
  // --------------------------------------------------------------------------
  logic signed [IN_W:0]        x_ext, y_ext, z_ext, z_abs, y_fold, x_neg;
  logic                        y_zero, z_neg;
  logic signed [ANG_W-1:0]     base_d;
  logic signed [atpr_pkg::NXK_W-1:0] nxk_d;

  logic                        s0_valid_q;
  logic signed [VEC_W-1:0]     s0_x_q, s0_y_q;
  logic signed [ANG_W-1:0]     s0_base_q;
  atpr_pkg::roll_side_t        s0_side_q, s0_side_d;

  always_comb begin
    x_ext  = {accel_x_i[IN_W-1], accel_x_i};
    y_ext  = {accel_y_i[IN_W-1], accel_y_i};
    z_ext  = {accel_z_i[IN_W-1], accel_z_i};
    z_neg  = accel_z_i[IN_W-1];
    y_zero = (accel_y_i == '0);
    z_abs  = z_neg ? -z_ext : z_ext;
    y_fold = z_neg ? -y_ext : y_ext;
    x_neg  = -x_ext;
    nxk_d  = atpr_pkg::NXK_W'(x_neg) * atpr_pkg::GAIN_Q16;
    // left half plane: turn by 180 and start the angle at +-180
    if (!z_neg) begin
      base_d = '0;
    end else if (!accel_y_i[IN_W-1]) begin
      base_d = atpr_pkg::DEG180_ACC;
    end else begin
      base_d = -atpr_pkg::DEG180_ACC;
    end
    s0_side_d.nxk    = nxk_d;
    s0_side_d.y_zero = y_zero;
    s0_side_d.z_neg  = z_neg;
    s0_side_d.z_zero = (accel_z_i == '0);
    s0_side_d.z_abs  = z_abs[IN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_x_q    <= {{(VEC_W-IN_W-17){z_abs[IN_W]}}, z_abs, 16'd0};
      s0_y_q    <= {{(VEC_W-IN_W-17){y_fold[IN_W]}}, y_fold, 16'd0};
      s0_base_q <= base_d;
      s0_side_q <= s0_side_d;
    end
  end

  // --------------------------------------------------------------------------
  // Roll chain
  // --------------------------------------------------------------------------
  logic                        c1_valid;
  logic signed [VEC_W-1:0]     c1_x;
  logic signed [ANG_W-1:0]     c1_ang;
  logic [RSIDE_W-1:0]          c1_side_w;
  atpr_pkg::roll_side_t        c1_side;

  atpr_cordic_chain #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (RSIDE_W)
  ) u_roll_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_valid_q),
    .x_i     (s0_x_q),
    .y_i     (s0_y_q),
    .ang_i   (s0_base_q),
    .side_i  (s0_side_q),
    .valid_o (c1_valid),
    .x_o     (c1_x),
    .ang_o   (c1_ang),
    .side_o  (c1_side_w)
  );

  assign c1_side = c1_side_w;

  // --------------------------------------------------------------------------
  // Middle stage: settle roll, pick the magnitude, classify pitch
  // --------------------------------------------------------------------------
  logic [atpr_pkg::PROD_W-1:0] zk_prod;
  logic signed [VEC_W-1:0]     mag_d;
  atpr_pkg::pitch_side_t       m_side_d, m_side_q;
  logic                        m_valid_q;
  logic signed [VEC_W-1:0]     m_mag_q, m_nxk_q;

  always_comb begin
    zk_prod = atpr_pkg::PROD_W'(c1_side.z_abs)
            * atpr_pkg::PROD_W'(atpr_pkg::GAIN_Q16);
    // y zero: skip the chain, magnitude is |z| * K
    if (c1_side.y_zero) begin
      mag_d             = VEC_W'(zk_prod);
      m_side_d.roll_acc = c1_side.z_neg ? atpr_pkg::DEG180_ACC : '0;
    end else begin
      mag_d             = c1_x;
      m_side_d.roll_acc = c1_ang;
    end
    if (c1_side.nxk == '0) begin
      m_side_d.pitch_sel = atpr_pkg::PITCH_ZERO;
    end else if (c1_side.y_zero && c1_side.z_zero) begin
      m_side_d.pitch_sel = c1_side.nxk[atpr_pkg::NXK_W-1] ? atpr_pkg::PITCH_NEG90
                                                          : atpr_pkg::PITCH_POS90;
    end else begin
      m_side_d.pitch_sel = atpr_pkg::PITCH_CHAIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= c1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_mag_q  <= mag_d;
      m_nxk_q  <= VEC_W'(c1_side.nxk);
      m_side_q <= m_side_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pitch chain
  // --------------------------------------------------------------------------
  logic                        c2_valid;
  logic signed [VEC_W-1:0]     c2_x;
  logic signed [ANG_W-1:0]     c2_ang;
  logic [PSIDE_W-1:0]          c2_side_w;
  atpr_pkg::pitch_side_t       c2_side;

  atpr_cordic_chain #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (PSIDE_W)
  ) u_pitch_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_valid_q),
    .x_i     (m_mag_q),
    .y_i     (m_nxk_q),
    .ang_i   ('0),
    .side_i  (m_side_q),
    .valid_o (c2_valid),
    .x_o     (c2_x),
    .ang_o   (c2_ang),
    .side_o  (c2_side_w)
  );

  assign c2_side = c2_side_w;

  // --------------------------------------------------------------------------
  // Quantize, then output register with a one-entry skid stage behind it
  // --------------------------------------------------------------------------
  logic signed [ANG_W-1:0]     pitch_acc, pitch_q, roll_q;
  logic signed [atpr_pkg::PITCH_W-1:0] pitch_res;
  logic signed [atpr_pkg::ROLL_W-1:0]  roll_res;
  logic signed [atpr_pkg::PITCH_W-1:0] out_pitch_q, out_pitch_d, skid_pitch_q, skid_pitch_d;
  logic signed [atpr_pkg::ROLL_W-1:0]  out_roll_q, out_roll_d, skid_roll_q, skid_roll_d;
  logic                        pipe_fire, out_take;

  always_comb begin
    unique case (c2_side.pitch_sel)
      atpr_pkg::PITCH_CHAIN: pitch_acc = c2_ang;
      atpr_pkg::PITCH_ZERO:  pitch_acc = '0;
      atpr_pkg::PITCH_POS90: pitch_acc = atpr_pkg::DEG90_ACC;
      atpr_pkg::PITCH_NEG90: pitch_acc = -atpr_pkg::DEG90_ACC;
      default:               pitch_acc = '0;
    endcase
    pitch_q   = quantize(pitch_acc, LIM_PITCH);
    roll_q    = quantize(c2_side.roll_acc, LIM_ROLL);
    pitch_res = pitch_q[atpr_pkg::PITCH_W-1:0];
    roll_res  = roll_q[atpr_pkg::ROLL_W-1:0];
  end

  assign pipe_fire = c2_valid && en;
  assign out_take  = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_pitch_d  = out_pitch_q;
    out_roll_d   = out_roll_q;
    skid_valid_d = skid_valid_q;
    skid_pitch_d = skid_pitch_q;
    skid_roll_d  = skid_roll_q;
    priority if (skid_valid_q) begin
      // drain the skid stage; the pipeline is held meanwhile
      if (out_take) begin
        out_pitch_d  = skid_pitch_q;
        out_roll_d   = skid_roll_q;
        skid_valid_d = 1'b0;
      end
    end else if (pipe_fire) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_d = 1'b1;
        out_pitch_d = pitch_res;
        out_roll_d  = roll_res;
      end else begin
        skid_valid_d = 1'b1;
        skid_pitch_d = pitch_res;
        skid_roll_d  = roll_res;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end else begin
      // hold both stages
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pitch_q  <= out_pitch_d;
    out_roll_q   <= out_roll_d;
    skid_pitch_q <= skid_pitch_d;
    skid_roll_q  <= skid_roll_d;
  end

  assign out_valid_o = out_valid_q;
  assign pitch_deg_o = out_pitch_q;
  assign roll_deg_o  = out_roll_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i && c2_valid))
    else $error("skid stage filled without a stalled output");

  a_skid_drain_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_valid_q) |-> $past(out_ready_i) && out_valid_q)
    else $error("skid stage emptied without the output being taken");

  a_no_intake_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> $stable(s0_valid_q) && $stable(c2_valid))
    else $error("pipeline advanced while the skid stage was full");

endmodule

// ===== hw/rtl/atpr_cordic_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_cordic_cell: one CORDIC vectoring step
// Rotates (x, y) toward the x axis by atan(2^-SHIFT), accumulates the angle
// and registers the result together with the sideband.
// ----------------------------------------------------------------------------
module atpr_cordic_cell #(
  parameter int unsigned SHIFT  = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [atpr_pkg::VEC_W-1:0]     x_i,
  input  logic signed [atpr_pkg::VEC_W-1:0]     y_i,
  input  logic signed [atpr_pkg::ANG_W-1:0]     ang_i,
  input  logic        [SIDE_W-1:0]              side_i,
  output logic                                  valid_o,
  output logic signed [atpr_pkg::VEC_W-1:0]     x_o,
  output logic signed [atpr_pkg::VEC_W-1:0]     y_o,
  output logic signed [atpr_pkg::ANG_W-1:0]     ang_o,
  output logic        [SIDE_W-1:0]              side_o
);

  localparam logic signed [atpr_pkg::ANG_W-1:0] STEP_ANG = atpr_pkg::ATAN_Q20[SHIFT];

  logic                                valid_q;
  logic signed [atpr_pkg::VEC_W-1:0]   x_q, y_q, x_d, y_d, x_sh, y_sh;
  logic signed [atpr_pkg::ANG_W-1:0]   ang_q, ang_d;
  logic        [SIDE_W-1:0]            side_q;

  // Floor shift, then rotate clockwise while y is non-negative
  always_comb begin
    x_sh = x_i >>> SHIFT;
    y_sh = y_i >>> SHIFT;
    if (!y_i[atpr_pkg::VEC_W-1]) begin
      x_d   = x_i + y_sh;
      y_d   = y_i - x_sh;
      ang_d = ang_i + STEP_ANG;
    end else begin
      x_d   = x_i - y_sh;
      y_d   = y_i + x_sh;
      ang_d = ang_i - STEP_ANG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      ang_q  <= ang_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ang_o   = ang_q;
  assign side_o  = side_q;

endmodule

// ===== hw/rtl/atpr_cordic_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_cordic_chain: row of CORDIC vectoring cells
// STEPS cells, cell i shifting by i, all advancing on a shared enable.
// ----------------------------------------------------------------------------
module atpr_cordic_chain #(
  parameter int unsigned STEPS  = atpr_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [atpr_pkg::VEC_W-1:0]     x_i,
  input  logic signed [atpr_pkg::VEC_W-1:0]     y_i,
  input  logic signed [atpr_pkg::ANG_W-1:0]     ang_i,
  input  logic        [SIDE_W-1:0]              side_i,
  output logic                                  valid_o,
  output logic signed [atpr_pkg::VEC_W-1:0]     x_o,
  output logic signed [atpr_pkg::ANG_W-1:0]     ang_o,
  output logic        [SIDE_W-1:0]              side_o
);

  logic                                valid_w [STEPS+1];
  logic signed [atpr_pkg::VEC_W-1:0]   x_w     [STEPS+1];
  logic signed [atpr_pkg::VEC_W-1:0]   y_w     [STEPS+1];
  logic signed [atpr_pkg::ANG_W-1:0]   ang_w   [STEPS+1];
  logic        [SIDE_W-1:0]            side_w  [STEPS+1];

  assign valid_w[0] = valid_i;
  assign x_w[0]     = x_i;
  assign y_w[0]     = y_i;
  assign ang_w[0]   = ang_i;
  assign side_w[0]  = side_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    atpr_cordic_cell #(
      .SHIFT  (i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_w[i]),
      .x_i     (x_w[i]),
      .y_i     (y_w[i]),
      .ang_i   (ang_w[i]),
      .side_i  (side_w[i]),
      .valid_o (valid_w[i+1]),
      .x_o     (x_w[i+1]),
      .y_o     (y_w[i+1]),
      .ang_o   (ang_w[i+1]),
      .side_o  (side_w[i+1])
    );
  end

  // Final y residue is not needed
  assign valid_o = valid_w[STEPS];
  assign x_o     = x_w[STEPS];
  assign ang_o   = ang_w[STEPS];
  assign side_o  = side_w[STEPS];

endmodule

// ===== tb/sv/tilt_angle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_angle_checker: predicts and compares pitch/roll results
// Watches the request and result channels of the tilt-angle unit. For each
// accepted request it computes pitch and roll with its own CORDIC model and
// queues them. Each accepted result is compared with the oldest queued pair.
// ----------------------------------------------------------------------------
module tilt_angle_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [atpr_pkg::IN_W-1:0]    accel_x_i,
  input  logic signed [atpr_pkg::IN_W-1:0]    accel_y_i,
  input  logic signed [atpr_pkg::IN_W-1:0]    accel_z_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [atpr_pkg::PITCH_W-1:0] pitch_deg_i,
  input  logic signed [atpr_pkg::ROLL_W-1:0]  roll_deg_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         waiting_o
);

  localparam int unsigned STEPS      = atpr_pkg::CORDIC_STEPS_DEF;
  localparam int unsigned ACC_SHIFT  = 20 - atpr_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int unsigned REPORT_MAX = 10;

  localparam longint K_GAIN     = 64'sd107922;
  localparam longint HALF_TURN  = 64'sd188743680;  // 180 deg, Q20
  localparam longint QUARTER    = 64'sd94371840;   // 90 deg, Q20

  // atan(2^-i) in degrees, Q20
  localparam longint ATAN_DEG [24] = '{
    64'sd47185920, 64'sd27855475, 64'sd14718068, 64'sd7471121,
    64'sd3750058,  64'sd1876857,  64'sd938658,   64'sd469357,
    64'sd234682,   64'sd117342,   64'sd58671,    64'sd29335,
    64'sd14668,    64'sd7334,     64'sd3667,     64'sd1833,
    64'sd917,      64'sd458,      64'sd229,      64'sd115,
    64'sd57,       64'sd29,       64'sd14,       64'sd7
  };

  typedef struct packed {
    logic signed [63:0] mag;
    logic signed [63:0] ang;
  } vector_out_t;

  typedef struct packed {
    logic signed [atpr_pkg::IN_W-1:0]    ax;
    logic signed [atpr_pkg::IN_W-1:0]    ay;
    logic signed [atpr_pkg::IN_W-1:0]    az;
    logic signed [atpr_pkg::PITCH_W-1:0] pitch;
    logic signed [atpr_pkg::ROLL_W-1:0]  roll;
  } tilt_angles_t;

  // Drive vy toward zero; vx grows to gain times the magnitude.
  function automatic vector_out_t rotate_to_axis(longint vx, longint vy);
    vector_out_t r;
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + ys;
        vy  = vy - xs;
        ang = ang + ATAN_DEG[i];
      end else begin
        vx  = vx - ys;
        vy  = vy + xs;
        ang = ang - ATAN_DEG[i];
      end
    end
    r.mag = vx;
    r.ang = ang;
    return r;
  endfunction

  // Round Q20 to the output format, ties up, then clamp symmetrically.
  function automatic longint round_angle(longint acc, longint lim_acc);
    longint lim;
    longint q;
    lim = lim_acc >>> ACC_SHIFT;
    q   = (acc + (64'sd1 <<< (ACC_SHIFT - 1))) >>> ACC_SHIFT;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic tilt_angles_t predict_tilt(logic signed [atpr_pkg::IN_W-1:0] ax,
                                                logic signed [atpr_pkg::IN_W-1:0] ay,
                                                logic signed [atpr_pkg::IN_W-1:0] az);
    tilt_angles_t r;
    vector_out_t  v;
    longint x, y, z, nx, mag, roll_acc, pitch_acc, base_acc, q;
    x = ax;
    y = ay;
    z = az;
    if (y == 0) begin
      roll_acc = (z < 0) ? HALF_TURN : 64'sd0;
      mag      = ((z < 0) ? -z : z) * K_GAIN;
    end else begin
      // fold the left half plane over before the chain
      if (z < 0) begin
        base_acc = (y > 0) ? HALF_TURN : -HALF_TURN;
        v = rotate_to_axis(-z * 65536, -y * 65536);
      end else begin
        base_acc = 0;
        v = rotate_to_axis(z * 65536, y * 65536);
      end
      roll_acc = base_acc + v.ang;
      mag      = v.mag;
    end
    nx = -x;
    if (nx == 0) begin
      pitch_acc = 0;
    end else if (mag == 0) begin
      pitch_acc = (nx > 0) ? QUARTER : -QUARTER;
    end else begin
      v = rotate_to_axis(mag, nx * K_GAIN);
      pitch_acc = v.ang;
    end
    r.ax = ax;
    r.ay = ay;
    r.az = az;
    q = round_angle(pitch_acc, QUARTER);
    r.pitch = q[atpr_pkg::PITCH_W-1:0];
    q = round_angle(roll_acc, HALF_TURN);
    r.roll = q[atpr_pkg::ROLL_W-1:0];
    return r;
  endfunction

  tilt_angles_t pending_angles [$];
  tilt_angles_t want;

  initial begin
    fail_count_o = 0;
    waiting_o    = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending_angles.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("unexpected result: pitch=%0d roll=%0d",
                     $signed(pitch_deg_i), $signed(roll_deg_i));
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pending_angles.pop_front();
          if (want.pitch !== pitch_deg_i || want.roll !== roll_deg_i) begin
            if (fail_count_o < REPORT_MAX)
              $display("mismatch x=%0d y=%0d z=%0d: expected pitch=%0d roll=%0d, got pitch=%0d roll=%0d",
                       $signed(want.ax), $signed(want.ay), $signed(want.az),
                       $signed(want.pitch), $signed(want.roll),
                       $signed(pitch_deg_i), $signed(roll_deg_i));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        pending_angles.push_back(predict_tilt(accel_x_i, accel_y_i, accel_z_i));
      waiting_o <= pending_angles.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the tilt-angle unit
// Sends directed corner samples, then random samples in bursts with gaps,
// while the result side stalls on changing patterns. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam int unsigned IDLE_LIMIT   = 3000;  // cycles with no handshake at all
  localparam int unsigned TAIL_CYCLES  = 60;    // run on after the queue drains

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [atpr_pkg::IN_W-1:0]    accel_x;
  logic signed [atpr_pkg::IN_W-1:0]    accel_y;
  logic signed [atpr_pkg::IN_W-1:0]    accel_z;
  logic out_valid;
  logic out_ready;
  logic signed [atpr_pkg::PITCH_W-1:0] pitch_deg;
  logic signed [atpr_pkg::ROLL_W-1:0]  roll_deg;

  int unsigned fail_count;
  int unsigned waiting;
  int unsigned idle_cycles;
  int unsigned sent;
  int unsigned burst;
  int unsigned k;
  int unsigned kind;
  logic [31:0] rnd_x, rnd_y, rnd_z;
  logic signed [atpr_pkg::IN_W-1:0] gx, gy, gz;

  accel_tilt_pitch_roll_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .accel_x_i   (accel_x),
    .accel_y_i   (accel_y),
    .accel_z_i   (accel_z),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pitch_deg_o (pitch_deg),
    .roll_deg_o  (roll_deg)
  );

  tilt_angle_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .accel_x_i    (accel_x),
    .accel_y_i    (accel_y),
    .accel_z_i    (accel_z),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .pitch_deg_i  (pitch_deg),
    .roll_deg_i   (roll_deg),
    .fail_count_o (fail_count),
    .waiting_o    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one request at a falling edge and hold it until accepted.
  // Return at the falling edge after acceptance with valid still high, so the
  // caller either follows with the next request or drops valid.
  task automatic send_sample(input logic signed [atpr_pkg::IN_W-1:0] sx,
                             input logic signed [atpr_pkg::IN_W-1:0] sy,
                             input logic signed [atpr_pkg::IN_W-1:0] sz);
    in_valid <= 1'b1;
    accel_x  <= sx;
    accel_y  <= sy;
    accel_z  <= sz;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Pick a corner value for one axis.
  function automatic logic signed [atpr_pkg::IN_W-1:0] corner_value(int unsigned sel);
    case (sel % 6)
      0: return -13'sd4096;
      1: return 13'sd4095;
      2: return 13'sd0;
      3: return -13'sd1;
      4: return 13'sd1;
      default: return 13'sd2048;
    endcase
  endfunction

  // Result side: switch between stall patterns after each random span.
  initial begin : result_stall
    int unsigned mode;
    int unsigned span;
    int unsigned hold;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 300);
      hold = 0;
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;                          // no back-pressure
          1: out_ready <= ($urandom_range(0, 3) != 0);   // light stalls
          2: out_ready <= ($urandom_range(0, 3) == 0);   // heavy stalls
          default: begin
            // alternate long stalls with short open windows
            if (hold == 0) begin
              out_ready <= ~out_ready;
              hold = out_ready ? $urandom_range(1, 30) : $urandom_range(1, 10);
            end else begin
              hold = hold - 1;
            end
          end
        endcase
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("** accel_tilt_pitch_roll_unit: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    accel_x  = '0;
    accel_y  = '0;
    accel_z  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    // directed: zero vector, axis cases, half-plane fold, extremes
    send_sample(0, 0, 0);
    send_sample(0, 0, 4095);
    send_sample(0, 0, -4096);
    send_sample(0, 0, 1);
    send_sample(0, 0, -1);
    send_sample(100, 0, 0);
    send_sample(-100, 0, 0);
    send_sample(4095, 0, 0);
    send_sample(-4096, 0, 0);
    send_sample(0, 4095, 0);
    send_sample(0, -4096, 0);
    send_sample(0, 1000, -1000);
    send_sample(0, -1000, -1000);
    send_sample(0, 1, -4096);
    send_sample(0, -1, -4096);
    send_sample(2000, 0, -3000);
    send_sample(-4096, -4096, -4096);
    send_sample(4095, 4095, 4095);
    send_sample(4095, -4096, 4095);
    send_sample(-4096, 4095, -4096);
    send_sample(1, 1, 1);
    send_sample(-1, -1, 1);
    send_sample(4095, 1, 0);
    send_sample(-4096, 0, -1);
    in_valid <= 1'b0;
    repeat (5) @(negedge clk);

    // random: bursts of requests with gaps, now and then a long stretch
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                          : $urandom_range(1, 24);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        rnd_x = $urandom;
        rnd_y = $urandom;
        rnd_z = $urandom;
        gx = rnd_x[atpr_pkg::IN_W-1:0];
        gy = rnd_y[atpr_pkg::IN_W-1:0];
        gz = rnd_z[atpr_pkg::IN_W-1:0];
        kind = $urandom_range(0, 9);
        case (kind)
          3: begin
            // small magnitudes, where rounding and the gain matter most
            gx = $urandom_range(0, 16) - 8;
            gy = $urandom_range(0, 16) - 8;
            gz = $urandom_range(0, 16) - 8;
          end
          4: gy = 0;
          5: begin
            gy = 0;
            gz = 0;
            if ($urandom_range(0, 3) == 0) gx = 0;
          end
          6: gx = 0;
          7: gz = 0;
          8: begin
            // near the +-180 seam of roll
            gy = $urandom_range(0, 6) - 3;
            gz = -$signed($urandom_range(1, 4096));
          end
          9: begin
            gx = corner_value($urandom);
            gy = corner_value($urandom);
            gz = corner_value($urandom);
          end
          default: ;
        endcase
        send_sample(gx, gy, gz);
        sent = sent + 1;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end

    // drain: wait for every queued result, then run on for TAIL_CYCLES
    while (waiting != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && waiting == 0) begin
      $display("** accel_tilt_pitch_roll_unit: PASSED **");
    end else begin
      $display("** accel_tilt_pitch_roll_unit: FAILED **");
    end
    $finish;
  end

endmodule
